/* sv/raster_dump_stream_parser_top_defines.svh */
// assertion macros shared by the raster dump stream parser modules
`ifndef RASTER_DUMP_STREAM_PARSER_TOP_DEFINES_SVH
`define RASTER_DUMP_STREAM_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, disabled while rst_n is low
`define RDSP_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, disabled while rst_n is low
`define RDSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rdsp_pkg.sv */
// shared types and constants of the raster dump stream parser
`default_nettype none

package rdsp_pkg;

  // most records one input item can produce
  localparam int RES_MAX = 4;
  // width of a record count (0 .. RES_MAX)
  localparam int CNT_W = $clog2(RES_MAX + 1);

  // parser phase
  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_WIDTH = 3'd1,
    PH_RECT  = 3'd2,
    PH_ROW   = 3'd3,
    PH_PKT   = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  // record kinds
  typedef enum logic [3:0] {
    REC_ORIGIN = 4'd0,
    REC_CORNER = 4'd1,
    REC_HEADER = 4'd2,
    REC_RSTART = 4'd3,
    REC_PHEAD  = 4'd4,
    REC_WORD   = 4'd5,
    REC_REND   = 4'd6,
    REC_DONE   = 4'd7,
    REC_EMPTY  = 4'd8
  } rec_kind_t;

  // one result record, without the last marker
  typedef struct packed {
    rec_kind_t          kind;
    logic [15:0]        raster_index;
    logic signed [20:0] value_a;
    logic signed [20:0] value_b;
    logic signed [16:0] value_c;
    logic               repeat_flag;
    logic               error_flag;
  } rec_t;

  // records produced by one accepted item
  typedef struct packed {
    logic                    load;
    logic [CNT_W-1:0]        count;
    rec_t [RES_MAX-1:0]      recs;
  } batch_t;

endpackage

`default_nettype wire

/* sv/rdsp_parser.sv */
// dump stream parser: state registers and per-item record generation
`default_nettype none
`include "raster_dump_stream_parser_top_defines.svh"

module rdsp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic                eos,
  input  logic [7:0]          data_byte,
  output rdsp_pkg::batch_t    batch
);

  rdsp_pkg::phase_t   phase_r, phase_nxt;
  logic               pend_r, pend_nxt;
  logic [7:0]         low_r, low_nxt;
  logic [2:0]         hidx_r, hidx_nxt;
  logic [15:0]        ox_r, ox_nxt;
  logic [15:0]        oy_r, oy_nxt;
  logic [15:0]        cx_r, cx_nxt;
  logic signed [16:0] total_r, total_nxt;
  logic signed [16:0] width_r, width_nxt;
  logic [15:0]        cur_r, cur_nxt;
  logic signed [17:0] row_left_r, row_left_nxt;
  logic [7:0]         pkt_left_r, pkt_left_nxt;
  logic [6:0]         pkt_pos_r, pkt_pos_nxt;

  logic [15:0]        word;
  logic signed [20:0] rsize;
  logic signed [16:0] diff_x;
  logic               do_start;
  logic               do_end;
  logic               end_more;
  logic               do_begin;
  logic               do_finish;
  logic               rep_bit;
  logic [6:0]         cnt7;
  logic [2:0]         n_res;
  rdsp_pkg::rec_t [rdsp_pkg::RES_MAX-1:0] lst;

  // build one record
  function automatic rdsp_pkg::rec_t mk_rec(
    input rdsp_pkg::rec_kind_t kind,
    input logic [15:0]         idx,
    input logic signed [20:0]  a,
    input logic signed [20:0]  b,
    input logic signed [16:0]  c,
    input logic                rep,
    input logic                err
  );
    rdsp_pkg::rec_t r;
    r.kind         = kind;
    r.raster_index = idx;
    r.value_a      = a;
    r.value_b      = b;
    r.value_c      = c;
    r.repeat_flag  = rep;
    r.error_flag   = err;
    return r;
  endfunction

  // (x + 15) / 16 rounded toward zero
  function automatic logic signed [16:0] div16_trunc(input logic signed [20:0] x);
    logic signed [21:0] s;
    logic signed [21:0] q;
    s = {x[20], x} + 22'sd15;
    if (s[21]) begin
      q = (s + 22'sd15) >>> 4;
    end else begin
      q = s >>> 4;
    end
    return q[16:0];
  endfunction

  // next state and record list for the item at the port
  always_comb begin
    phase_nxt    = phase_r;
    pend_nxt     = pend_r;
    low_nxt      = low_r;
    hidx_nxt     = hidx_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    cx_nxt       = cx_r;
    total_nxt    = total_r;
    width_nxt    = width_r;
    cur_nxt      = cur_r;
    row_left_nxt = row_left_r;
    pkt_left_nxt = pkt_left_r;
    pkt_pos_nxt  = pkt_pos_r;
    word         = {data_byte, low_r};
    rsize        = '0;
    diff_x       = $signed({1'b0, cx_r}) - $signed({1'b0, ox_r});
    do_start     = 1'b0;
    do_end       = 1'b0;
    end_more     = 1'b0;
    do_begin     = 1'b0;
    do_finish    = 1'b0;
    rep_bit      = data_byte[7];
    cnt7         = data_byte[6:0];
    n_res        = '0;
    lst          = '0;

    if (take && (phase_r != rdsp_pkg::PH_DONE)) begin
      if (eos) begin
        // end of stream: drop half word, close raster or dump
        pend_nxt = 1'b0;
        if ((phase_r == rdsp_pkg::PH_ROW) || (phase_r == rdsp_pkg::PH_PKT)) begin
          do_end = 1'b1;
        end else begin
          do_finish = 1'b1;
        end
      end else if (phase_r == rdsp_pkg::PH_ROW) begin
        // packet head byte
        lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_PHEAD, cur_r, $signed({14'b0, cnt7}),
                                 '0, '0, rep_bit, 1'b0);
        n_res = n_res + 3'd1;
        row_left_nxt = row_left_r - $signed({11'b0, cnt7});
        pkt_left_nxt = rep_bit ? 8'd1 : {1'b0, cnt7};
        pkt_pos_nxt  = '0;
        pend_nxt     = 1'b0;
        if (pkt_left_nxt != 8'd0) begin
          phase_nxt = rdsp_pkg::PH_PKT;
        end else if (row_left_nxt[17] || (row_left_nxt == 18'sd0)) begin
          do_end   = 1'b1;
          end_more = 1'b1;
        end
      end else if (!pend_r) begin
        // low byte of a word
        low_nxt  = data_byte;
        pend_nxt = 1'b1;
      end else begin
        // high byte completes a word
        pend_nxt = 1'b0;
        unique case (phase_r)
          rdsp_pkg::PH_COUNT: begin
            if (word != 16'd0) begin
              total_nxt = $signed({1'b0, word});
              phase_nxt = rdsp_pkg::PH_WIDTH;
            end else begin
              hidx_nxt  = '0;
              phase_nxt = rdsp_pkg::PH_RECT;
            end
          end
          rdsp_pkg::PH_WIDTH: begin
            if (word[15]) begin
              rsize     = $signed({6'b0, word[14:0]});
              width_nxt = div16_trunc(rsize);
            end else begin
              rsize     = $signed({1'b0, word, 4'b0});
              width_nxt = $signed({1'b0, word});
            end
            do_start = 1'b1;
          end
          rdsp_pkg::PH_RECT: begin
            hidx_nxt = hidx_r + 3'd1;
            unique case (hidx_r[1:0])
              2'd0: ox_nxt = word;
              2'd1: oy_nxt = word;
              2'd2: cx_nxt = word;
              2'd3: ;
            endcase
            if (hidx_nxt == 3'd2) begin
              lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_ORIGIN, '0, $signed({5'b0, ox_r}),
                                       $signed({5'b0, word}), '0, 1'b0, 1'b0);
              n_res = n_res + 3'd1;
            end else if (hidx_nxt >= 3'd4) begin
              total_nxt = $signed({1'b0, word}) - $signed({1'b0, oy_r});
              rsize     = {{4{diff_x[16]}}, diff_x};
              width_nxt = div16_trunc(rsize);
              lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_CORNER, '0, $signed({5'b0, cx_r}),
                                       $signed({5'b0, word}), '0, 1'b0, 1'b0);
              n_res = n_res + 3'd1;
              do_start = 1'b1;
            end
          end
          rdsp_pkg::PH_PKT: begin
            lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_WORD, cur_r, $signed({5'b0, word}),
                                     $signed({14'b0, pkt_pos_r}), '0, 1'b0, 1'b0);
            n_res = n_res + 3'd1;
            pkt_pos_nxt = pkt_pos_r + 7'd1;
            if (pkt_left_r != 8'd0) begin
              pkt_left_nxt = pkt_left_r - 8'd1;
            end
            if (pkt_left_nxt == 8'd0) begin
              if (!row_left_r[17] && (row_left_r != 18'sd0)) begin
                phase_nxt = rdsp_pkg::PH_ROW;
              end else begin
                do_end   = 1'b1;
                end_more = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      // header record and what follows it
      if (do_start) begin
        lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_HEADER, '0, {{4{total_nxt[16]}}, total_nxt},
                                 rsize, width_nxt, 1'b0, 1'b0);
        n_res = n_res + 3'd1;
        if (total_nxt[16] || (total_nxt == 17'sd0)) begin
          do_finish = 1'b1;
        end else if (width_nxt[16] || (width_nxt == 17'sd0)) begin
          lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_EMPTY, '0,
                                   {{4{total_nxt[16]}}, total_nxt}, '0, '0, 1'b0, 1'b0);
          n_res = n_res + 3'd1;
          do_finish = 1'b1;
        end else begin
          cur_nxt  = 16'd1;
          do_begin = 1'b1;
        end
      end

      // raster end record, then next raster or done
      if (do_end) begin
        lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_REND, cur_r,
                                 {{3{row_left_nxt[17]}}, row_left_nxt},
                                 {{3{row_left_nxt[17]}}, row_left_nxt}, '0, 1'b0,
                                 row_left_nxt != 18'sd0);
        n_res = n_res + 3'd1;
        if (end_more && ($signed({1'b0, cur_r}) < total_r)) begin
          cur_nxt  = cur_r + 16'd1;
          do_begin = 1'b1;
        end else begin
          do_finish = 1'b1;
        end
      end

      // raster start
      if (do_begin) begin
        row_left_nxt = {width_nxt[16], width_nxt};
        lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_RSTART, cur_nxt, '0, '0, '0, 1'b0, 1'b0);
        n_res = n_res + 3'd1;
        phase_nxt = rdsp_pkg::PH_ROW;
      end

      // done record
      if (do_finish) begin
        lst[n_res[1:0]] = mk_rec(rdsp_pkg::REC_DONE, '0, '0, '0, '0, 1'b0, 1'b0);
        n_res = n_res + 3'd1;
        phase_nxt = rdsp_pkg::PH_DONE;
      end
    end
  end

  // record list to the output buffer
  always_comb begin
    batch.load  = take;
    batch.count = n_res;
    batch.recs  = lst;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rdsp_pkg::PH_COUNT;
      pend_r     <= 1'b0;
      hidx_r     <= '0;
      total_r    <= '0;
      width_r    <= '0;
      cur_r      <= '0;
      row_left_r <= '0;
      pkt_left_r <= '0;
      pkt_pos_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pend_r     <= pend_nxt;
      hidx_r     <= hidx_nxt;
      total_r    <= total_nxt;
      width_r    <= width_nxt;
      cur_r      <= cur_nxt;
      row_left_r <= row_left_nxt;
      pkt_left_r <= pkt_left_nxt;
      pkt_pos_r  <= pkt_pos_nxt;
    end
  end

  // held bytes and rectangle words
  always_ff @(posedge clk) begin
    low_r <= low_nxt;
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
    cx_r  <= cx_nxt;
  end

  // checks
  `RDSP_ASSERT_NEXT(a_done_sticky, phase_r == rdsp_pkg::PH_DONE, phase_r == rdsp_pkg::PH_DONE, "parser left done phase")
  `RDSP_ASSERT_HOLDS(a_pkt_nonempty, phase_r == rdsp_pkg::PH_PKT, pkt_left_r != 8'd0, "packet phase with no words left")
  `RDSP_ASSERT_HOLDS(a_row_no_half_word, phase_r == rdsp_pkg::PH_ROW, !pend_r, "half word held at packet head")

endmodule

`default_nettype wire

/* sv/rdsp_outbuf.sv */
// result buffer: holds the records of one item and hands them out in order
`default_nettype none
`include "raster_dump_stream_parser_top_defines.svh"

module rdsp_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  rdsp_pkg::batch_t batch,
  output logic             space,
  output rdsp_pkg::rec_t   head,
  output logic             head_valid,
  output logic             head_last,
  input  logic             head_ready
);

  rdsp_pkg::rec_t [rdsp_pkg::RES_MAX-1:0] rec_r, rec_nxt;
  logic [rdsp_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                                   pop;

  // handshake on the head entry
  assign pop        = (cnt_r != '0) && head_ready;
  assign space      = (cnt_r == '0) || ((cnt_r == rdsp_pkg::CNT_W'(1)) && head_ready);
  assign head       = rec_r[0];
  assign head_valid = (cnt_r != '0);
  assign head_last  = (cnt_r == rdsp_pkg::CNT_W'(1));

  // load a new list or shift toward the head
  always_comb begin
    rec_nxt = rec_r;
    cnt_nxt = cnt_r;
    if (batch.load) begin
      rec_nxt = batch.recs;
      cnt_nxt = batch.count;
    end else if (pop) begin
      for (int i = 0; i < rdsp_pkg::RES_MAX - 1; i++) begin
        rec_nxt[i] = rec_r[i+1];
      end
      cnt_nxt = cnt_r - rdsp_pkg::CNT_W'(1);
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  // checks
  `RDSP_ASSERT_HOLDS(a_no_overwrite, batch.load, (cnt_r == '0) || ((cnt_r == rdsp_pkg::CNT_W'(1)) && head_ready), "new records loaded over pending ones")
  `RDSP_ASSERT_NEXT(a_hold_on_stall, (cnt_r > rdsp_pkg::CNT_W'(1)) && !head_ready, cnt_r == $past(cnt_r), "pending records changed while stalled")

endmodule

`default_nettype wire

/* sv/raster_dump_stream_parser_top.sv */
// Run-length raster dump stream parser.
// Input channel (in_*): one dump byte per item in in_tdata; in_tuser high marks
// end of stream instead of a byte. Output channel (out_*): typed records
// (origin, corner, header, raster start, packet head, word, raster end, done,
// empty rasters); out_tlast marks the last record caused by one input item.
// Records of an item accepted at one clock edge are shown on out_* from the
// next cycle. An input item yields zero to four records, handed out one per
// cycle while out_tready is high; the next input is taken in the cycle the last
// of them leaves, so with out_tready high one-record (or no-record) items run
// at one item per cycle and longer items hold the input while their records
// drain. The four-entry record buffer between parser and output port sets this.
// If out_tready stays low, the buffered records hold and in_tready stays low
// until the buffer drains. Reset (rst_n low, synchronous) returns the parser to
// the header count word and empties the buffer. After the done record all
// further input, end of stream too, is taken and dropped until the next reset.
`default_nettype none

module raster_dump_stream_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [15:0] raster_index, [36:16] value_a, [57:37] value_b,
                                  // [74:58] value_c, [75] repeat_flag, [76] error_flag,
                                  // [79:77] zero
  output logic [3:0]  out_tuser,  // [3:0] rec_kind
  output logic        out_tlast   // last
);

  rdsp_pkg::batch_t batch;
  rdsp_pkg::rec_t   head;
  logic             space;
  logic             take;

  assign in_tready = space;
  assign take      = in_tvalid && space;

  // byte parser
  rdsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .eos       (in_tuser),
    .data_byte (in_tdata),
    .batch     (batch)
  );

  // record buffer
  rdsp_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .batch      (batch),
    .space      (space),
    .head       (head),
    .head_valid (out_tvalid),
    .head_last  (out_tlast),
    .head_ready (out_tready)
  );

  // pack the output item
  assign out_tuser = head.kind;
  assign out_tdata = {3'b0, head.error_flag, head.repeat_flag, head.value_c,
                      head.value_b, head.value_a, head.raster_index};

endmodule

`default_nettype wire
